// ===== hdl/csep_pkg.sv =====
// ----------------------------------------------------------------------------
// csep_pkg
// Shared constants, types and helpers of the coefficient sign / Exp-Golomb
// packer.
// ----------------------------------------------------------------------------
package csep_pkg;

  localparam int MAX_COEFFS  = 64;
  localparam int COEFF_AW    = $clog2(MAX_COEFFS);
  localparam int CNT_W       = COEFF_AW + 1;
  localparam int STORE_AW    = COEFF_AW + 1;   // bank bit plus entry index
  localparam int STORE_DEPTH = 2 * MAX_COEFFS;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Bit buffer: up to 23 held bits plus one 15-bit code.
  localparam int BUF_W  = 38;
  localparam int FILL_W = 6;

  localparam logic [7:0] MAG_SAT = 8'd254;

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_COEFF  = 1'b1;

  // One unit of back-end work: a short bit field, then ncodes stored codes.
  typedef struct packed {
    logic [7:0]       bits;
    logic [3:0]       len;
    logic [CNT_W-1:0] ncodes;
    logic             bank;
  } csep_job_t;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } csep_wr_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HEAD,
    BK_READ,
    BK_CODE,
    BK_FLUSH
  } csep_bk_state_t;

  // floor(log2(code)) for a nonzero 8-bit code
  function automatic logic [2:0] eg_prefix(input logic [7:0] code);
    logic [2:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (code[i]) p = 3'(i);
    end
    return p;
  endfunction

endpackage

// ===== hdl/csep_coeff_if.sv =====
// ----------------------------------------------------------------------------
// csep_coeff_if
// Input channel: header fields and coefficients, valid/ready handshake.
// ----------------------------------------------------------------------------
interface csep_coeff_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic signed [8:0] value;
  logic [3:0]        field_bits;
  logic              block_last;

  modport source (output valid, cmd, value, field_bits, block_last, input ready);
  modport sink   (input valid, cmd, value, field_bits, block_last, output ready);
endinterface

// ===== hdl/csep_stream_if.sv =====
// ----------------------------------------------------------------------------
// csep_stream_if
// Output channel: one or two completed stream bytes per beat.
// ----------------------------------------------------------------------------
interface csep_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [1:0] byte_count;
  logic       run_last;

  modport source (output valid, first_byte, second_byte, byte_count, run_last,
                  input ready);
  modport sink   (input valid, first_byte, second_byte, byte_count, run_last,
                  output ready);
endinterface

// ===== hdl/coeff_sign_expgolomb_packer_top.sv =====
// ----------------------------------------------------------------------------
// coeff_sign_expgolomb_packer_top
// MSB-first entropy packer for quantized coefficient blocks.
// ----------------------------------------------------------------------------
// Usage and timing: each beat on coeff is a header field (cmd 0, low
// field_bits bits of value, clamped to eight) or a coefficient (cmd 1),
// whose sign bit goes to the stream at once and whose magnitude, saturated
// to 254, is stored. The coefficient with block_last set makes the block's
// stored magnitudes go out, in arrival order, as order-0 Exp-Golomb codes of
// magnitude+1. Completed bytes leave on stream two per beat; the last beat
// caused by an input has run_last set and may carry a single byte. An input
// that completes no byte gives no beat. The partial byte carries over from
// one input to the next. Rate: the front end takes one item per cycle while
// its four-entry job queue has room; coefficients stall while two finished
// blocks wait on the packer (one magnitude bank each). The packer handles a
// header or plain coefficient by dequeue, append and flush, and each stored
// magnitude on block end by a registered store read, then an append. It sends
// an output beat from the flush step, or whenever 24 or more bits are pending
// and the output register is free; appends wait meanwhile. The packer takes
// one job at a time, so once the queue fills, the front end waits on it.
// ----------------------------------------------------------------------------
module coeff_sign_expgolomb_packer_top (
  input  logic           clk,
  input  logic           rst,
  csep_coeff_if.sink     coeff,
  csep_stream_if.source  stream
);
  import csep_pkg::*;

  // front end to queue
  logic                q_not_full;
  logic                push;
  csep_job_t           push_job;
  csep_wr_t            wr;

  // queue to packer
  logic                q_empty;
  logic                pop;
  csep_job_t           head_job;

  // packer to store and front end
  logic [STORE_AW-1:0] rd_addr;
  logic [7:0]          rd_data;
  logic                blk_done;

  // Classify items, write magnitudes, queue one job per item.
  csep_front u_front (
    .clk        (clk),
    .rst        (rst),
    .coeff      (coeff),
    .q_not_full (q_not_full),
    .push       (push),
    .push_job   (push_job),
    .wr         (wr),
    .blk_done   (blk_done)
  );

  // Decouple the two sides so each may stall on its own.
  csep_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .not_full (q_not_full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  // Two banks: the front end fills one block while the packer codes another.
  csep_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Append bits, emit one or two bytes per beat through the output register.
  csep_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head_job (head_job),
    .pop      (pop),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .blk_done (blk_done),
    .stream   (stream)
  );
endmodule

// ===== hdl/csep_store.sv =====
// ----------------------------------------------------------------------------
// csep_store
// Two-bank magnitude memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module csep_store (
  input  logic                          clk,
  input  csep_pkg::csep_wr_t            wr,
  input  logic [csep_pkg::STORE_AW-1:0] rd_addr,
  output logic [7:0]                    rd_data
);
  import csep_pkg::*;

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== hdl/csep_queue.sv =====
// ----------------------------------------------------------------------------
// csep_queue
// Short job queue between the front end and the bit packer.
// ----------------------------------------------------------------------------
module csep_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  csep_pkg::csep_job_t push_job,
  output logic                not_full,
  input  logic                pop,
  output csep_pkg::csep_job_t head_job,
  output logic                empty
);
  import csep_pkg::*;

  csep_job_t             entry [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     fill;

  assign not_full = (fill != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign head_job = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
    end
  end
endmodule

// ===== hdl/csep_front.sv =====
// ----------------------------------------------------------------------------
// csep_front
// Accepts items, stores coefficient magnitudes and queues bit jobs.
// ----------------------------------------------------------------------------
module csep_front (
  input  logic                clk,
  input  logic                rst,
  csep_coeff_if.sink          coeff,
  input  logic                q_not_full,
  output logic                push,
  output csep_pkg::csep_job_t push_job,
  output csep_pkg::csep_wr_t  wr,
  input  logic                blk_done
);
  import csep_pkg::*;

  logic [CNT_W-1:0] coeff_count;
  logic             wbank;
  logic [1:0]       pending;

  logic             is_coeff;
  logic             neg;
  logic [9:0]       mag_wide;
  logic [7:0]       mag;
  logic             has_room;
  logic [3:0]       hdr_len;
  logic [15:0]      hdr_shift;
  logic [7:0]       hdr_bits;
  logic             blk_push;
  logic [CNT_W-1:0] block_codes;

  assign is_coeff = (coeff.cmd == CMD_COEFF);

  // Hold coefficients while both banks wait on the packer.
  assign coeff.ready = q_not_full && (!is_coeff || pending != 2'd2);
  assign push        = coeff.valid && coeff.ready;

  assign neg      = coeff.value[8];
  assign mag_wide = neg ? (10'd0 - {coeff.value[8], coeff.value}) : {1'b0, coeff.value};
  assign mag      = (mag_wide > {2'b00, MAG_SAT}) ? MAG_SAT : mag_wide[7:0];
  assign has_room = (coeff_count < CNT_W'(MAX_COEFFS));

  assign hdr_len   = (coeff.field_bits > 4'd8) ? 4'd8 : coeff.field_bits;
  assign hdr_shift = 16'h00FF << hdr_len;
  assign hdr_bits  = coeff.value[7:0] & ~hdr_shift[7:0];

  assign blk_push    = push && is_coeff && coeff.block_last;
  assign block_codes = coeff_count + CNT_W'(has_room);

  always_comb begin
    push_job.bank = wbank;
    if (is_coeff) begin
      push_job.bits   = {7'd0, neg};
      push_job.len    = 4'd1;
      push_job.ncodes = coeff.block_last ? block_codes : '0;
    end else begin
      push_job.bits   = hdr_bits;
      push_job.len    = hdr_len;
      push_job.ncodes = '0;
    end
  end

  assign wr.en   = push && is_coeff && has_room;
  assign wr.addr = {wbank, coeff_count[COEFF_AW-1:0]};
  assign wr.data = mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_count <= '0;
      wbank       <= 1'b0;
      pending     <= '0;
    end else begin
      if (blk_push) begin
        coeff_count <= '0;
        wbank       <= ~wbank;
      end else if (wr.en) begin
        coeff_count <= coeff_count + 1'b1;
      end
      pending <= pending + 2'(blk_push) - 2'(blk_done);
    end
  end
endmodule

// ===== hdl/csep_back.sv =====
// ----------------------------------------------------------------------------
// csep_back
// Bit packer: appends fields and Exp-Golomb codes, emits bytes in pairs or singly.
// ----------------------------------------------------------------------------
module csep_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  csep_pkg::csep_job_t           head_job,
  output logic                          pop,
  output logic [csep_pkg::STORE_AW-1:0] rd_addr,
  input  logic [7:0]                    rd_data,
  output logic                          blk_done,
  csep_stream_if.source                 stream
);
  import csep_pkg::*;

  csep_bk_state_t    state;
  csep_bk_state_t    state_next;
  csep_job_t         job;
  logic [CNT_W-1:0]  idx;
  logic [BUF_W-1:0]  bit_buf;
  logic [FILL_W-1:0] nfill;

  logic              out_valid;
  logic [7:0]        out_first;
  logic [7:0]        out_second;
  logic [1:0]        out_count;
  logic              out_last;

  logic              out_free;
  logic              room;
  logic              append_en;
  logic [14:0]       app_val;
  logic [3:0]        app_len;
  logic              emit_en;
  logic              emit_two;
  logic              emit_last;
  logic              job_done;
  logic [7:0]        code;
  logic [2:0]        prefix;
  logic              last_code;
  logic [FILL_W-1:0] sh;
  logic [BUF_W-1:0]  window;

  assign out_free  = !out_valid || stream.ready;
  assign room      = (nfill < FILL_W'(24));
  assign code      = rd_data + 8'd1;
  assign prefix    = eg_prefix(code);
  assign last_code = ((idx + 1'b1) == job.ncodes);
  assign rd_addr   = {job.bank, idx[COEFF_AW-1:0]};

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (!q_empty) state_next = BK_HEAD;
      BK_HEAD:  if (room) state_next = (job.ncodes != '0) ? BK_READ : BK_FLUSH;
      BK_READ:  state_next = BK_CODE;
      BK_CODE:  if (room) state_next = last_code ? BK_FLUSH : BK_READ;
      BK_FLUSH: if (nfill < FILL_W'(8)) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    append_en = 1'b0;
    app_val   = '0;
    app_len   = '0;
    emit_en   = out_free && !room;
    job_done  = 1'b0;
    unique case (state)
      BK_IDLE:  pop = !q_empty;
      BK_HEAD: begin
        append_en = room;
        app_val   = 15'(job.bits);
        app_len   = job.len;
      end
      BK_READ:  ;
      BK_CODE: begin
        append_en = room;
        app_val   = 15'(code);
        app_len   = {prefix, 1'b1};
      end
      BK_FLUSH: begin
        emit_en  = out_free && (nfill >= FILL_W'(8));
        job_done = (nfill < FILL_W'(8));
      end
      default:  ;
    endcase
  end

  // Hold back a pair until a third byte or the job's end shows it is final.
  assign emit_two  = (state != BK_FLUSH) || (nfill >= FILL_W'(16));
  assign emit_last = (state == BK_FLUSH) &&
                     (!emit_two || nfill < FILL_W'(24));
  assign sh        = nfill - (emit_two ? FILL_W'(16) : FILL_W'(8));
  assign window    = bit_buf >> sh;
  assign blk_done  = job_done && (job.ncodes != '0);

  always_ff @(posedge clk) begin
    if (pop) job <= head_job;
    if (append_en) bit_buf <= (bit_buf << app_len) | BUF_W'(app_val);
    if (emit_en) begin
      out_first  <= emit_two ? window[15:8] : window[7:0];
      out_second <= emit_two ? window[7:0]  : 8'd0;
      out_count  <= emit_two ? 2'd2 : 2'd1;
      out_last   <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      idx       <= '0;
      nfill     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        idx <= '0;
      end else if (state == BK_CODE && append_en) begin
        idx <= idx + 1'b1;
      end
      if (append_en) begin
        nfill <= nfill + FILL_W'(app_len);
      end else if (emit_en) begin
        nfill <= sh;
      end
      if (emit_en) begin
        out_valid <= 1'b1;
      end else if (stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stream.valid       = out_valid;
  assign stream.first_byte  = out_first;
  assign stream.second_byte = out_second;
  assign stream.byte_count  = out_count;
  assign stream.run_last    = out_last;
endmodule

// ===== hdl/csep_checker.sv =====
// ----------------------------------------------------------------------------
// csep_checker
// Port-level checks on the packer's output stream.
// ----------------------------------------------------------------------------
module csep_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] first_byte,
  input logic [7:0] second_byte,
  input logic [1:0] byte_count,
  input logic       run_last
);

  // No beat can be pending right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("stream valid after reset");

  // A single-byte beat only closes an input's run.
  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_count == 2'd1) |-> run_last)
    else $error("single-byte beat without run_last");

  // A single-byte beat carries a zero second byte.
  a_single_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_count == 2'd1) |-> (second_byte == 8'd0))
    else $error("single-byte beat with nonzero second byte");

  // A stalled beat holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(first_byte) &&
      $stable(second_byte) && $stable(byte_count) && $stable(run_last)))
    else $error("stalled beat changed");

endmodule

bind coeff_sign_expgolomb_packer_top csep_checker u_csep_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (stream.valid),
  .out_ready   (stream.ready),
  .first_byte  (stream.first_byte),
  .second_byte (stream.second_byte),
  .byte_count  (stream.byte_count),
  .run_last    (stream.run_last)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the coefficient sign / Exp-Golomb packer.
// ----------------------------------------------------------------------------
// A directed table opens the run. It covers the clamped and zero-length
// header fields, the magnitude saturation corners, a header with block_last
// set, and single-coefficient blocks. Random traffic follows. Most of it is
// coefficient blocks of random length, with headers mixed in, stray
// block_last marks, and blocks that run past the store limit. A scoreboard
// tracks the bit stream and predicts every output beat. Each beat that leaves
// the packer is compared field by field with the oldest prediction. Both
// channels idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import csep_pkg::*;

  localparam int DIRECTED_ROWS = 21;
  localparam int RANDOM_ITEMS  = 450;
  localparam int TOTAL_ITEMS   = DIRECTED_ROWS + RANDOM_ITEMS;
  localparam int CALM_ITEMS    = 60;    // final stretch with no idling at all
  localparam int PRESSURE_AT   = 200;   // drain the packer once past this many
  localparam int IDLE_LIMIT    = 1000;  // cycles with no beat on either side
  localparam int TAIL_CYCLES   = 100;
  localparam int REPORT_MAX    = 10;

  // One output beat as the scoreboard holds it.
  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [1:0] byte_count;
    logic       run_last;
  } beat_t;

  // Directed row: the item, and optionally its result typed in by hand.
  // A typed row with t_count 0 must produce no beat at all.
  typedef struct {
    logic       cmd;
    logic [8:0] value;
    logic [3:0] nbits;
    logic       last;
    bit         typed;
    logic [7:0] t_byte;
    logic [1:0] t_count;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  csep_coeff_if  coeff ();
  csep_stream_if stream ();

  coeff_sign_expgolomb_packer_top dut (
    .clk    (clk),
    .rst    (rst),
    .coeff  (coeff),
    .stream (stream)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  stim_row_t stim_rows [DIRECTED_ROWS] = '{
    // Headers right after reset: the partial byte is empty, so each 8-bit
    // field comes straight out as one single-byte beat.
    '{CMD_HEADER, 9'h0AB, 4'd8,  1'b0, 1'b1, 8'hAB, 2'd1},
    '{CMD_HEADER, 9'h0FF, 4'd15, 1'b0, 1'b1, 8'hFF, 2'd1},  // length clamps to 8
    '{CMD_HEADER, 9'h1C3, 4'd0,  1'b1, 1'b1, 8'h00, 2'd0},  // zero length, no bits
    '{CMD_HEADER, 9'h15A, 4'd9,  1'b0, 1'b1, 8'h5A, 2'd1},  // top value bit dropped
    '{CMD_HEADER, 9'h1FF, 4'd8,  1'b0, 1'b1, 8'hFF, 2'd1},
    // Saturation corners: -255, 255 and -256 all store 254.
    '{CMD_COEFF,  9'h101, 4'd0,  1'b0, 1'b0, 8'h00, 2'd0},
    '{CMD_COEFF,  9'h0FF, 4'd15, 1'b0, 1'b0, 8'h00, 2'd0},
    '{CMD_COEFF,  9'h100, 4'd0,  1'b0, 1'b0, 8'h00, 2'd0},
    '{CMD_COEFF,  9'h000, 4'd0,  1'b0, 1'b0, 8'h00, 2'd0},
    // Mid-block header carrying block_last: must not close the block.
    '{CMD_HEADER, 9'h003, 4'd3,  1'b1, 1'b0, 8'h00, 2'd0},
    '{CMD_COEFF,  9'h1FF, 4'd0,  1'b1, 1'b0, 8'h00, 2'd0},
    '{CMD_HEADER, 9'h005, 4'd3,  1'b0, 1'b0, 8'h00, 2'd0},
    '{CMD_COEFF,  9'h001, 4'd0,  1'b1, 1'b0, 8'h00, 2'd0},  // one-coefficient block
    '{CMD_COEFF,  9'h180, 4'd0,  1'b0, 1'b0, 8'h00, 2'd0},
    '{CMD_COEFF,  9'h07F, 4'd0,  1'b0, 1'b0, 8'h00, 2'd0},
    '{CMD_COEFF,  9'h0AA, 4'hA,  1'b0, 1'b0, 8'h00, 2'd0},
    '{CMD_COEFF,  9'h1AA, 4'd5,  1'b1, 1'b0, 8'h00, 2'd0},
    '{CMD_HEADER, 9'h055, 4'd7,  1'b0, 1'b0, 8'h00, 2'd0},
    '{CMD_HEADER, 9'h001, 4'd1,  1'b0, 1'b0, 8'h00, 2'd0},
    '{CMD_COEFF,  9'h0FE, 4'd0,  1'b1, 1'b0, 8'h00, 2'd0},
    '{CMD_HEADER, 9'h000, 4'd5,  1'b0, 1'b0, 8'h00, 2'd0}
  };

  // --------------------------------------------------------------------------
  // Bit-stream scoreboard
  // --------------------------------------------------------------------------
  logic [7:0] mag_mem [MAX_COEFFS];  // magnitudes of the open block
  int         blk_fill;              // magnitudes held for the open block
  logic [7:0] part_byte;             // partial byte, right-aligned
  int         part_bits;
  logic [7:0] done_bytes [$];        // bytes completed by the current item
  beat_t      pending_beats [$];     // predicted beats, oldest first

  int row_tag;                       // directed row in flight, -1 when random
  int items_sent;
  int gap_pct;
  bit calm;

  int headers_seen, coeffs_seen, blocks_closed, dropped_mags;
  int beats_seen, fail_count, idle_run;

  // Append one bit; move the byte out once eight are collected.
  function automatic void shift_in(input logic b);
    part_byte = {part_byte[6:0], b};
    part_bits++;
    if (part_bits == 8) begin
      done_bytes.push_back(part_byte);
      part_byte = '0;
      part_bits = 0;
    end
  endfunction

  // Order-0 Exp-Golomb code of mag+1: leading zeros, then the code MSB first.
  function automatic void shift_eg0(input int mag);
    int code, lead;
    code = mag + 1;
    lead = 0;
    while ((code >> (lead + 1)) != 0) lead++;
    repeat (lead) shift_in(1'b0);
    for (int i = lead; i >= 0; i--) shift_in(code[i]);
  endfunction

  // Advance the scoreboard by one accepted item and queue its beats.
  function automatic void pack_item(input logic cmd, input logic [8:0] raw,
                                    input logic [3:0] nbits, input logic last);
    int    len, mag;
    beat_t b;
    done_bytes.delete();
    if (cmd == CMD_HEADER) begin
      len = (nbits > 4'd8) ? 8 : int'(nbits);
      for (int k = len - 1; k >= 0; k--) shift_in(raw[k]);
    end else begin
      if (raw[8]) begin
        mag = (512 - int'(raw)) & 511;
        if (mag == 0) mag = 256;
      end else begin
        mag = int'(raw);
      end
      if (mag > int'(MAG_SAT)) mag = int'(MAG_SAT);
      shift_in(raw[8]);
      // Past the store limit only the sign bit survives.
      if (blk_fill < MAX_COEFFS) begin
        mag_mem[blk_fill] = 8'(mag);
        blk_fill++;
      end else begin
        dropped_mags++;
      end
      if (last) begin
        for (int k = 0; k < blk_fill; k++) shift_eg0(int'(mag_mem[k]));
        blk_fill = 0;
        blocks_closed++;
      end
    end
    for (int k = 0; k < done_bytes.size(); k += 2) begin
      b.first_byte = done_bytes[k];
      if (k + 1 < done_bytes.size()) begin
        b.second_byte = done_bytes[k + 1];
        b.byte_count  = 2'd2;
      end else begin
        b.second_byte = 8'h00;
        b.byte_count  = 2'd1;
      end
      b.run_last = (k + 2 >= done_bytes.size());
      pending_beats.push_back(b);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predict on accepted input beats, check accepted output beats.
  // Both handshakes are sampled at the same edge, so a prediction is always
  // queued before any beat that it could cause.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    int    n_before;
    beat_t got, want;
    if (rst) begin
      blk_fill  = 0;
      part_byte = '0;
      part_bits = 0;
      idle_run  = 0;
    end else begin
      if (coeff.valid && coeff.ready) begin
        if (coeff.cmd == CMD_HEADER) headers_seen++;
        else coeffs_seen++;
        n_before = pending_beats.size();
        pack_item(coeff.cmd, coeff.value, coeff.field_bits, coeff.block_last);
        // Rows with a hand-typed result replace the prediction; the scoreboard
        // state still advances.
        if (row_tag >= 0 && stim_rows[row_tag].typed) begin
          while (pending_beats.size() > n_before) void'(pending_beats.pop_back());
          if (stim_rows[row_tag].t_count != 2'd0) begin
            want.first_byte  = stim_rows[row_tag].t_byte;
            want.second_byte = 8'h00;
            want.byte_count  = stim_rows[row_tag].t_count;
            want.run_last    = 1'b1;
            pending_beats.push_back(want);
          end
        end
      end

      if (stream.valid && stream.ready) begin
        beats_seen++;
        got.first_byte  = stream.first_byte;
        got.second_byte = stream.second_byte;
        got.byte_count  = stream.byte_count;
        got.run_last    = stream.run_last;
        if (pending_beats.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("ERROR: unexpected beat %02h %02h count %0d run_last %0b",
                     got.first_byte, got.second_byte, got.byte_count, got.run_last);
        end else begin
          want = pending_beats.pop_front();
          if (got.first_byte !== want.first_byte || got.second_byte !== want.second_byte ||
              got.byte_count !== want.byte_count || got.run_last !== want.run_last) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("ERROR: beat %0d expected %02h %02h n%0d l%0b, got %02h %02h n%0d l%0b",
                       beats_seen, want.first_byte, want.second_byte, want.byte_count,
                       want.run_last, got.first_byte, got.second_byte, got.byte_count,
                       got.run_last);
          end
        end
      end

      if ((coeff.valid && coeff.ready) || (stream.valid && stream.ready)) idle_run = 0;
      else idle_run++;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if the channels go quiet for too long.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    @(posedge clk);
    while (idle_run < IDLE_LIMIT) @(posedge clk);
    $display("ERROR: no beat moved on either channel for %0d cycles", IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: hold ready low in random bursts. The burst rate
  // drifts so that some stretches see no stalls at all.
  // --------------------------------------------------------------------------
  initial begin : stream_sink
    int hold, stall_pct;
    stall_pct = 15;
    stream.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 49) == 0)
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      if (!rst && !calm && $urandom_range(0, 99) < stall_pct) begin
        stream.ready <= 1'b0;
        hold = $urandom_range(1, 5);
        repeat (hold - 1) @(posedge clk);
      end else begin
        stream.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Drive one item, wait for its handshake, then maybe leave a gap.
  // Without a gap valid stays high, so the next call reuses this edge.
  task automatic send_item(input logic cmd, input logic [8:0] val,
                           input logic [3:0] nbits, input logic last, input int tag);
    coeff.valid      <= 1'b1;
    coeff.cmd        <= cmd;
    coeff.value      <= val;
    coeff.field_bits <= nbits;
    coeff.block_last <= last;
    row_tag          <= tag;
    @(posedge clk);
    while (!coeff.ready) @(posedge clk);
    items_sent++;
    calm = (items_sent >= TOTAL_ITEMS - CALM_ITEMS);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      coeff.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Mostly legal lengths; now and then any length from zero to fifteen.
  task automatic send_random_header();
    send_item(CMD_HEADER, 9'($urandom_range(0, 511)),
              ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 8)),
              1'($urandom_range(0, 1)), -1);
  endtask

  // Coefficient values: small ones near zero, full 9-bit patterns, corners.
  function automatic logic [8:0] pick_coeff();
    case ($urandom_range(0, 5))
      0, 1:    return 9'($urandom_range(0, 6) - 3);
      2:       return 9'($urandom_range(0, 511));
      3: begin
        case ($urandom_range(0, 5))
          0:       return 9'h0FF;
          1:       return 9'h101;
          2:       return 9'h100;
          3:       return 9'h0FE;
          4:       return 9'h102;
          default: return 9'h000;
        endcase
      end
      default: return 9'($urandom_range(0, 60) - 30);
    endcase
  endfunction

  initial begin : stimulus
    int   blen;
    logic blk_last;
    bit   first_blk, squeezed;

    coeff.valid      <= 1'b0;
    coeff.cmd        <= CMD_HEADER;
    coeff.value      <= '0;
    coeff.field_bits <= '0;
    coeff.block_last <= 1'b0;
    row_tag          <= -1;
    rst              <= 1'b1;
    items_sent = 0;
    calm       = 1'b0;
    gap_pct    = 20;
    headers_seen = 0;
    coeffs_seen  = 0;
    blocks_closed = 0;
    dropped_mags  = 0;
    beats_seen = 0;
    fail_count = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table.
    foreach (stim_rows[r])
      send_item(stim_rows[r].cmd, stim_rows[r].value, stim_rows[r].nbits,
                stim_rows[r].last, r);

    // Random blocks. The first one overruns the store to hit the drop path.
    first_blk = 1'b1;
    squeezed  = 1'b0;
    while (items_sent < TOTAL_ITEMS) begin
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      if (!first_blk && $urandom_range(0, 4) == 0) begin
        send_random_header();
      end else begin
        if (first_blk) blen = MAX_COEFFS + 6;
        else if ($urandom_range(0, 19) == 0) blen = $urandom_range(MAX_COEFFS - 8, MAX_COEFFS + 8);
        else blen = $urandom_range(1, 12);
        first_blk = 1'b0;
        for (int j = 0; j < blen; j++) begin
          if ($urandom_range(0, 15) == 0) send_random_header();
          // Stray block_last splits a block now and then.
          blk_last = (j == blen - 1) || ($urandom_range(0, 40) == 0);
          send_item(CMD_COEFF, pick_coeff(), 4'($urandom_range(0, 15)), blk_last, -1);
        end
      end

      // Hold off once until the packer has drained everything it owes.
      if (!squeezed && items_sent >= PRESSURE_AT) begin
        squeezed = 1'b1;
        if (coeff.valid) coeff.valid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0) @(posedge clk);
      end
    end

    // Drain, then watch for stray beats.
    if (coeff.valid) coeff.valid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d items: %0d header fields, %0d coefficients, %0d blocks coded,",
             items_sent, headers_seen, coeffs_seen, blocks_closed);
    $display("  %0d magnitudes dropped past the store limit, %0d beats checked, %0d failures",
             dropped_mags, beats_seen, fail_count);
    if (fail_count == 0 && pending_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== coeff_sign_expgolomb_packer_top.f =====
hdl/csep_pkg.sv
hdl/csep_coeff_if.sv
hdl/csep_stream_if.sv
hdl/csep_store.sv
hdl/csep_queue.sv
hdl/csep_front.sv
hdl/csep_back.sv
hdl/coeff_sign_expgolomb_packer_top.sv
hdl/csep_checker.sv
tb/tb_top.sv
